// ===== rtl/stc_pkg.sv =====
`timescale 1ns / 1ps

package stc_pkg;

   localparam int COORD_W    = 32;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int CROSS_W    = PROD_W + 1;
   localparam int BARY_W     = CROSS_W + 2;
   localparam int REM_W      = CROSS_W + 1;
   localparam int ALPHA_BITS = 30;
   localparam int ALPHA_W    = ALPHA_BITS + 1;
   localparam int NEAR_W     = 16;
   localparam int NEAR_SQ_W  = 2 * NEAR_W + 1;
   localparam int LERP_W     = DIFF_W + ALPHA_W;
   localparam int STEP_W     = LERP_W - ALPHA_BITS;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE  = {1'b1, {ALPHA_BITS{1'b0}}};
   localparam logic [LERP_W-1:0]  LERP_HALF  = LERP_W'(1) << (ALPHA_BITS - 1);

   typedef enum logic [1:0] {
      CASE_VERTEX   = 2'd0,
      CASE_TWO_EDGE = 2'd1,
      CASE_ONE_EDGE = 2'd2,
      CASE_INSIDE   = 2'd3
   } clip_case_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } point_type;

   typedef struct packed {
      point_type [2:0] v;
      point_type       s;
      point_type       e;
   } geo_type;

   typedef struct packed {
      geo_type    geo;
      logic [2:0] hit;
      logic [2:0] full;
      logic       ins_s;
      logic       ins_e;
      logic       near_s;
      logic       near_e;
   } carry_type;

   function automatic logic signed [DIFF_W-1:0] coord_diff(input logic [COORD_W-1:0] a,
                                                           input logic [COORD_W-1:0] b);
      return $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
   endfunction

   function automatic logic signed [CROSS_W-1:0] cross_sub(input logic [PROD_W-1:0] p,
                                                          input logic [PROD_W-1:0] q);
      return $signed({p[PROD_W-1], p}) - $signed({q[PROD_W-1], q});
   endfunction

   function automatic logic same_side(input logic [CROSS_W-1:0] a,
                                      input logic [CROSS_W-1:0] b);
      return (a != '0) && (b != '0) && (a[CROSS_W-1] == b[CROSS_W-1]);
   endfunction

   function automatic logic [CROSS_W-1:0] cross_mag(input logic [CROSS_W-1:0] a);
      return a[CROSS_W-1] ? (~a + CROSS_W'(1)) : a;
   endfunction

   function automatic logic bary_ok(input logic [CROSS_W-1:0] det,
                                    input logic [CROSS_W-1:0] l0,
                                    input logic [CROSS_W-1:0] l1);
      logic signed [BARY_W-1:0] d;
      logic signed [BARY_W-1:0] a;
      logic signed [BARY_W-1:0] b;
      logic signed [BARY_W-1:0] c;
      logic signed [BARY_W-1:0] vals [6];
      logic                     bad;
      d = $signed({{2{det[CROSS_W-1]}}, det});
      a = $signed({{2{l0[CROSS_W-1]}}, l0});
      b = $signed({{2{l1[CROSS_W-1]}}, l1});
      c = d - a - b;
      vals[0] = a;
      vals[1] = d - a;
      vals[2] = b;
      vals[3] = d - b;
      vals[4] = c;
      vals[5] = d - c;
      bad = 1'b0;
      for (int i = 0; i < 6; i++) begin
         if ((vals[i] != '0) && (vals[i][BARY_W-1] != d[BARY_W-1])) begin
            bad = 1'b1;
         end
      end
      return (d != '0) && !bad;
   endfunction

endpackage

// ===== rtl/segment_triangle_clip.sv =====
`timescale 1ns / 1ps

// throughput: one item per cycle unless rsp_tready stalls the output register;
//    the 30-step restoring divider for the crossing parameter is fully pipelined,
//    one quotient bit per stage
// items that give no result drop out at the output register
// reset clears all valid bits and sets vertex_tolerance to 1
module segment_triangle_clip #(
   parameter int ELEM_INDEX_BITS = 24,
   localparam int REQ_W = ((ELEM_INDEX_BITS + 10 * stc_pkg::COORD_W + 7) / 8) * 8,
   localparam int RSP_W = ((ELEM_INDEX_BITS + 1 + 4 * stc_pkg::COORD_W + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // elem_index, tri_x0, tri_y0, tri_x1, tri_y1, tri_x2, tri_y2,
   // seg_x_start, seg_y_start, seg_x_end, seg_y_end
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // out_elem_id, clip_x_start, clip_y_start, clip_x_end, clip_y_end
   output logic [RSP_W-1:0] rsp_tdata,
   // clip_case
   output logic [1:0]       rsp_tuser,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [15:0]      csr_wdata
);
   import stc_pkg::*;

   localparam int EW = ELEM_INDEX_BITS;

   logic adv;

   logic [NEAR_W-1:0]      tol_ff;
   logic [2*NEAR_W-1:0]    tol_sq_ff;

   // stage 0: input register
   logic          s0_valid_ff;
   logic [EW-1:0] s0_elem_ff;
   geo_type       s0_geo_ff;

   // stage 1: differences
   logic                     s1_valid_ff;
   logic [EW-1:0]            s1_elem_ff;
   geo_type                  s1_geo_ff;
   logic signed [DIFF_W-1:0] s1_ase_x_ff [3];
   logic signed [DIFF_W-1:0] s1_ase_y_ff [3];
   logic signed [DIFF_W-1:0] s1_aee_x_ff [3];
   logic signed [DIFF_W-1:0] s1_aee_y_ff [3];
   logic signed [DIFF_W-1:0] s1_ed_x_ff [3];
   logic signed [DIFF_W-1:0] s1_ed_y_ff [3];
   logic signed [DIFF_W-1:0] s1_dse_x_ff;
   logic signed [DIFF_W-1:0] s1_dse_y_ff;
   logic [NEAR_W-1:0]        s1_ns_x_ff [3];
   logic [NEAR_W-1:0]        s1_ns_y_ff [3];
   logic [NEAR_W-1:0]        s1_ne_x_ff [3];
   logic [NEAR_W-1:0]        s1_ne_y_ff [3];
   logic [2:0]               s1_ns_ok_ff;
   logic [2:0]               s1_ne_ok_ff;

   // stage 2: products
   logic                     s2_valid_ff;
   logic [EW-1:0]            s2_elem_ff;
   geo_type                  s2_geo_ff;
   logic signed [PROD_W-1:0] s2_pa_ff [3];
   logic signed [PROD_W-1:0] s2_pb_ff [3];
   logic signed [PROD_W-1:0] s2_pc_ff [3];
   logic signed [PROD_W-1:0] s2_pd_ff [3];
   logic signed [PROD_W-1:0] s2_pe_ff [3];
   logic signed [PROD_W-1:0] s2_pf_ff [3];
   logic signed [PROD_W-1:0] s2_pg_ff [3];
   logic signed [PROD_W-1:0] s2_ph_ff [3];
   logic signed [PROD_W-1:0] s2_pt_ff [2];
   logic signed [PROD_W-1:0] s2_pq_ff [4];
   logic [NEAR_SQ_W-1:0]     s2_ds_ff [3];
   logic [NEAR_SQ_W-1:0]     s2_de_ff [3];
   logic [2:0]               s2_ns_ok_ff;
   logic [2:0]               s2_ne_ok_ff;

   // stage 3: cross products
   logic                s3_valid_ff;
   logic [EW-1:0]       s3_elem_ff;
   geo_type             s3_geo_ff;
   logic [CROSS_W-1:0]  s3_os_ff [3];
   logic [CROSS_W-1:0]  s3_t3_ff [3];
   logic [CROSS_W-1:0]  s3_t4_ff [3];
   logic [CROSS_W-1:0]  s3_dt_ff [3];
   logic [CROSS_W-1:0]  s3_dtri_ff;
   logic [CROSS_W-1:0]  s3_l0s_ff;
   logic [CROSS_W-1:0]  s3_l0e_ff;
   logic                s3_near_s_ff;
   logic                s3_near_e_ff;

   // stage 4 and divider steps
   logic                dv_valid_ff [0:ALPHA_BITS];
   logic [EW-1:0]       dv_elem_ff  [0:ALPHA_BITS];
   carry_type           dv_cy_ff    [0:ALPHA_BITS];
   logic [REM_W-1:0]    dv_r_ff     [0:ALPHA_BITS][3];
   logic [REM_W-1:0]    dv_d_ff     [0:ALPHA_BITS][3];
   logic [ALPHA_BITS-1:0] dv_q_ff   [0:ALPHA_BITS][3];
   logic                dv_valid_in [0:ALPHA_BITS];
   logic [EW-1:0]       dv_elem_in  [0:ALPHA_BITS];
   carry_type           dv_cy_in    [0:ALPHA_BITS];
   logic [REM_W-1:0]    dv_r_in     [0:ALPHA_BITS][3];
   logic [REM_W-1:0]    dv_d_in     [0:ALPHA_BITS][3];
   logic [ALPHA_BITS-1:0] dv_q_in   [0:ALPHA_BITS][3];

   // decision stage
   logic               dc_valid_ff;
   logic               dc_has_ff;
   clip_case_type      dc_kind_ff;
   logic [ALPHA_W-1:0] dc_c1_ff;
   logic [ALPHA_W-1:0] dc_c2_ff;
   logic               dc_usev_ff;
   point_type          dc_vert_ff;
   logic [EW-1:0]      dc_elem_ff;
   point_type          dc_s_ff;
   point_type          dc_e_ff;
   logic               dc_has_in;
   clip_case_type      dc_kind_in;
   logic [ALPHA_W-1:0] dc_c1_in;
   logic [ALPHA_W-1:0] dc_c2_in;
   logic               dc_usev_in;
   point_type          dc_vert_in;

   // interpolation products
   logic               lm_valid_ff;
   logic               lm_has_ff;
   clip_case_type      lm_kind_ff;
   logic               lm_usev_ff;
   point_type          lm_vert_ff;
   logic [EW-1:0]      lm_elem_ff;
   point_type          lm_s_ff;
   logic               lm_neg_x_ff;
   logic               lm_neg_y_ff;
   logic [LERP_W-1:0]  lm_px1_ff;
   logic [LERP_W-1:0]  lm_py1_ff;
   logic [LERP_W-1:0]  lm_px2_ff;
   logic [LERP_W-1:0]  lm_py2_ff;

   // output register
   logic               rsp_valid_ff;
   logic [EW:0]        rsp_id_ff;
   point_type          rsp_p0_ff;
   point_type          rsp_p1_ff;
   clip_case_type      rsp_case_ff;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_case_ff;

   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[EW:0]                          = rsp_id_ff;
      rsp_tdata[EW + 1 + 0 * COORD_W +: COORD_W] = rsp_p0_ff.x;
      rsp_tdata[EW + 1 + 1 * COORD_W +: COORD_W] = rsp_p0_ff.y;
      rsp_tdata[EW + 1 + 2 * COORD_W +: COORD_W] = rsp_p1_ff.x;
      rsp_tdata[EW + 1 + 3 * COORD_W +: COORD_W] = rsp_p1_ff.y;
   end

   // config register
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= NEAR_W'(1);
      end else if (csr_valid) begin
         tol_ff <= csr_wdata;
      end
      tol_sq_ff <= tol_ff * tol_ff;
   end

   // stage 1 logic
   geo_type                  s1_geo_in;
   logic signed [DIFF_W-1:0] s1_ase_x_in [3];
   logic signed [DIFF_W-1:0] s1_ase_y_in [3];
   logic signed [DIFF_W-1:0] s1_aee_x_in [3];
   logic signed [DIFF_W-1:0] s1_aee_y_in [3];
   logic signed [DIFF_W-1:0] s1_ed_x_in [3];
   logic signed [DIFF_W-1:0] s1_ed_y_in [3];
   logic [DIFF_W-1:0]        mag_sx [3];
   logic [DIFF_W-1:0]        mag_sy [3];
   logic [DIFF_W-1:0]        mag_ex [3];
   logic [DIFF_W-1:0]        mag_ey [3];

   always_comb begin
      s1_geo_in = s0_geo_ff;
      for (int i = 0; i < 3; i++) begin
         s1_ase_x_in[i] = coord_diff(s0_geo_ff.v[i].x, s0_geo_ff.s.x);
         s1_ase_y_in[i] = coord_diff(s0_geo_ff.v[i].y, s0_geo_ff.s.y);
         s1_aee_x_in[i] = coord_diff(s0_geo_ff.v[i].x, s0_geo_ff.e.x);
         s1_aee_y_in[i] = coord_diff(s0_geo_ff.v[i].y, s0_geo_ff.e.y);
         s1_ed_x_in[i]  = coord_diff(s0_geo_ff.v[(i + 1) % 3].x, s0_geo_ff.v[i].x);
         s1_ed_y_in[i]  = coord_diff(s0_geo_ff.v[(i + 1) % 3].y, s0_geo_ff.v[i].y);
         mag_sx[i] = s1_ase_x_in[i][DIFF_W-1] ? -s1_ase_x_in[i] : s1_ase_x_in[i];
         mag_sy[i] = s1_ase_y_in[i][DIFF_W-1] ? -s1_ase_y_in[i] : s1_ase_y_in[i];
         mag_ex[i] = s1_aee_x_in[i][DIFF_W-1] ? -s1_aee_x_in[i] : s1_aee_x_in[i];
         mag_ey[i] = s1_aee_y_in[i][DIFF_W-1] ? -s1_aee_y_in[i] : s1_aee_y_in[i];
      end
   end

   // stage 4 logic and divider steps, one quotient bit each
   logic [CROSS_W-1:0] n_mag [3];
   logic [CROSS_W-1:0] d_mag [3];
   logic [REM_W-1:0]   shifted;

   always_comb begin
      dv_valid_in[0]      = s3_valid_ff;
      dv_elem_in[0]       = s3_elem_ff;
      dv_cy_in[0].geo     = s3_geo_ff;
      dv_cy_in[0].ins_s   = bary_ok(s3_dtri_ff, s3_l0s_ff, s3_t3_ff[2]);
      dv_cy_in[0].ins_e   = bary_ok(s3_dtri_ff, s3_l0e_ff, s3_t4_ff[2]);
      dv_cy_in[0].near_s  = s3_near_s_ff;
      dv_cy_in[0].near_e  = s3_near_e_ff;
      for (int k = 0; k < 3; k++) begin
         dv_cy_in[0].hit[k] = !same_side(s3_os_ff[k], s3_os_ff[(k + 1) % 3])
                              && !same_side(s3_t3_ff[k], s3_t4_ff[k])
                              && (s3_dt_ff[k] != '0);
         n_mag[k] = cross_mag(s3_t3_ff[k]);
         d_mag[k] = cross_mag(s3_dt_ff[k]);
         dv_cy_in[0].full[k] = (n_mag[k] >= d_mag[k]);
         dv_r_in[0][k] = {1'b0, n_mag[k]};
         dv_d_in[0][k] = {1'b0, d_mag[k]};
         dv_q_in[0][k] = '0;
      end
      shifted = '0;
      for (int j = 0; j < ALPHA_BITS; j++) begin
         dv_valid_in[j+1] = dv_valid_ff[j];
         dv_elem_in[j+1]  = dv_elem_ff[j];
         dv_cy_in[j+1]    = dv_cy_ff[j];
         for (int k = 0; k < 3; k++) begin
            shifted = {dv_r_ff[j][k][REM_W-2:0], 1'b0};
            dv_d_in[j+1][k] = dv_d_ff[j][k];
            dv_q_in[j+1][k] = dv_q_ff[j][k];
            if (shifted >= dv_d_ff[j][k]) begin
               dv_r_in[j+1][k] = shifted - dv_d_ff[j][k];
               dv_q_in[j+1][k][ALPHA_BITS-1-j] = 1'b1;
            end else begin
               dv_r_in[j+1][k] = shifted;
            end
         end
      end
   end

   // decision logic
   logic [ALPHA_W-1:0] al [3];
   logic [1:0]         hit_cnt;
   logic [ALPHA_W-1:0] ax;
   logic [ALPHA_W-1:0] ay;
   carry_type          cy;

   always_comb begin
      cy = dv_cy_ff[ALPHA_BITS];
      for (int k = 0; k < 3; k++) begin
         al[k] = cy.full[k] ? ALPHA_ONE : {1'b0, dv_q_ff[ALPHA_BITS][k]};
      end
      hit_cnt = 2'({1'b0, cy.hit[0]} + {1'b0, cy.hit[1]} + {1'b0, cy.hit[2]});
      ax = '0;
      ay = '0;
      dc_has_in  = 1'b0;
      dc_kind_in = CASE_INSIDE;
      dc_c1_in   = '0;
      dc_c2_in   = ALPHA_ONE;
      dc_usev_in = 1'b0;
      dc_vert_in = cy.geo.v[0];
      unique case (hit_cnt)
         2'd3: begin
            dc_kind_in = CASE_VERTEX;
            dc_usev_in = 1'b1;
            dc_has_in  = 1'b1;
            priority if (al[0] != '0 && al[0] != ALPHA_ONE) begin
               dc_c1_in   = al[0];
               dc_vert_in = cy.geo.v[2];
            end else if (al[1] != '0 && al[1] != ALPHA_ONE) begin
               dc_c1_in   = al[1];
               dc_vert_in = cy.geo.v[0];
            end else if (al[2] != '0 && al[2] != ALPHA_ONE) begin
               dc_c1_in   = al[2];
               dc_vert_in = cy.geo.v[1];
            end else begin
               dc_has_in = 1'b0;
            end
         end
         2'd2: begin
            dc_kind_in = CASE_TWO_EDGE;
            ax = cy.hit[0] ? al[0] : al[1];
            ay = cy.hit[2] ? al[2] : al[1];
            dc_has_in = (ax != ay);
            dc_c1_in  = (ax < ay) ? ax : ay;
            dc_c2_in  = (ax < ay) ? ay : ax;
         end
         2'd1: begin
            dc_kind_in = CASE_ONE_EDGE;
            ax = cy.hit[0] ? al[0] : (cy.hit[1] ? al[1] : al[2]);
            priority if (cy.ins_s || (!cy.ins_e && cy.near_s)) begin
               dc_has_in = 1'b1;
               dc_c1_in  = '0;
               dc_c2_in  = ax;
            end else if (cy.ins_e || cy.near_e) begin
               dc_has_in = 1'b1;
               dc_c1_in  = ax;
               dc_c2_in  = ALPHA_ONE;
            end else begin
               dc_has_in = 1'b0;
            end
         end
         default: begin
            dc_kind_in = CASE_INSIDE;
            dc_has_in  = cy.ins_s && cy.ins_e;
         end
      endcase
   end

   // interpolation inputs
   logic signed [DIFF_W-1:0] lx_diff;
   logic signed [DIFF_W-1:0] ly_diff;
   logic [DIFF_W-1:0]        lx_mag;
   logic [DIFF_W-1:0]        ly_mag;

   always_comb begin
      lx_diff = coord_diff(dc_e_ff.x, dc_s_ff.x);
      ly_diff = coord_diff(dc_e_ff.y, dc_s_ff.y);
      lx_mag  = lx_diff[DIFF_W-1] ? -lx_diff : lx_diff;
      ly_mag  = ly_diff[DIFF_W-1] ? -ly_diff : ly_diff;
   end

   // rounding and final add
   logic [STEP_W-1:0] rx1;
   logic [STEP_W-1:0] ry1;
   logic [STEP_W-1:0] rx2;
   logic [STEP_W-1:0] ry2;
   point_type         rsp_p0_in;
   point_type         rsp_p1_in;

   always_comb begin
      rx1 = STEP_W'((lm_px1_ff + LERP_HALF) >> ALPHA_BITS);
      ry1 = STEP_W'((lm_py1_ff + LERP_HALF) >> ALPHA_BITS);
      rx2 = STEP_W'((lm_px2_ff + LERP_HALF) >> ALPHA_BITS);
      ry2 = STEP_W'((lm_py2_ff + LERP_HALF) >> ALPHA_BITS);
      rsp_p0_in.x = lm_neg_x_ff ? lm_s_ff.x - rx1[COORD_W-1:0] : lm_s_ff.x + rx1[COORD_W-1:0];
      rsp_p0_in.y = lm_neg_y_ff ? lm_s_ff.y - ry1[COORD_W-1:0] : lm_s_ff.y + ry1[COORD_W-1:0];
      if (lm_usev_ff) begin
         rsp_p1_in = lm_vert_ff;
      end else begin
         rsp_p1_in.x = lm_neg_x_ff ? lm_s_ff.x - rx2[COORD_W-1:0]
                                   : lm_s_ff.x + rx2[COORD_W-1:0];
         rsp_p1_in.y = lm_neg_y_ff ? lm_s_ff.y - ry2[COORD_W-1:0]
                                   : lm_s_ff.y + ry2[COORD_W-1:0];
      end
   end

   // pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         for (int j = 0; j <= ALPHA_BITS; j++) begin
            dv_valid_ff[j] <= 1'b0;
         end
         dc_valid_ff  <= 1'b0;
         lm_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff  <= req_tvalid;
         s1_valid_ff  <= s0_valid_ff;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         for (int j = 0; j <= ALPHA_BITS; j++) begin
            dv_valid_ff[j] <= dv_valid_in[j];
         end
         dc_valid_ff  <= dv_valid_ff[ALPHA_BITS];
         lm_valid_ff  <= dc_valid_ff;
         rsp_valid_ff <= lm_valid_ff && lm_has_ff;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (adv) begin
         s0_elem_ff   <= req_tdata[EW-1:0];
         s0_geo_ff.v[0].x <= req_tdata[EW + 0 * COORD_W +: COORD_W];
         s0_geo_ff.v[0].y <= req_tdata[EW + 1 * COORD_W +: COORD_W];
         s0_geo_ff.v[1].x <= req_tdata[EW + 2 * COORD_W +: COORD_W];
         s0_geo_ff.v[1].y <= req_tdata[EW + 3 * COORD_W +: COORD_W];
         s0_geo_ff.v[2].x <= req_tdata[EW + 4 * COORD_W +: COORD_W];
         s0_geo_ff.v[2].y <= req_tdata[EW + 5 * COORD_W +: COORD_W];
         s0_geo_ff.s.x    <= req_tdata[EW + 6 * COORD_W +: COORD_W];
         s0_geo_ff.s.y    <= req_tdata[EW + 7 * COORD_W +: COORD_W];
         s0_geo_ff.e.x    <= req_tdata[EW + 8 * COORD_W +: COORD_W];
         s0_geo_ff.e.y    <= req_tdata[EW + 9 * COORD_W +: COORD_W];

         s1_elem_ff  <= s0_elem_ff;
         s1_geo_ff   <= s1_geo_in;
         s1_dse_x_ff <= coord_diff(s0_geo_ff.e.x, s0_geo_ff.s.x);
         s1_dse_y_ff <= coord_diff(s0_geo_ff.e.y, s0_geo_ff.s.y);
         for (int i = 0; i < 3; i++) begin
            s1_ase_x_ff[i] <= s1_ase_x_in[i];
            s1_ase_y_ff[i] <= s1_ase_y_in[i];
            s1_aee_x_ff[i] <= s1_aee_x_in[i];
            s1_aee_y_ff[i] <= s1_aee_y_in[i];
            s1_ed_x_ff[i]  <= s1_ed_x_in[i];
            s1_ed_y_ff[i]  <= s1_ed_y_in[i];
            s1_ns_x_ff[i]  <= mag_sx[i][NEAR_W-1:0];
            s1_ns_y_ff[i]  <= mag_sy[i][NEAR_W-1:0];
            s1_ne_x_ff[i]  <= mag_ex[i][NEAR_W-1:0];
            s1_ne_y_ff[i]  <= mag_ey[i][NEAR_W-1:0];
            s1_ns_ok_ff[i] <= (mag_sx[i][DIFF_W-1:NEAR_W] == '0)
                              && (mag_sy[i][DIFF_W-1:NEAR_W] == '0);
            s1_ne_ok_ff[i] <= (mag_ex[i][DIFF_W-1:NEAR_W] == '0)
                              && (mag_ey[i][DIFF_W-1:NEAR_W] == '0);
         end

         s2_elem_ff  <= s1_elem_ff;
         s2_geo_ff   <= s1_geo_ff;
         s2_ns_ok_ff <= s1_ns_ok_ff;
         s2_ne_ok_ff <= s1_ne_ok_ff;
         for (int i = 0; i < 3; i++) begin
            s2_pa_ff[i] <= s1_dse_x_ff * s1_ase_y_ff[i];
            s2_pb_ff[i] <= s1_dse_y_ff * s1_ase_x_ff[i];
            s2_pc_ff[i] <= s1_ed_y_ff[i] * s1_ase_x_ff[i];
            s2_pd_ff[i] <= s1_ed_x_ff[i] * s1_ase_y_ff[i];
            s2_pe_ff[i] <= s1_ed_y_ff[i] * s1_aee_x_ff[i];
            s2_pf_ff[i] <= s1_ed_x_ff[i] * s1_aee_y_ff[i];
            s2_pg_ff[i] <= s1_ed_x_ff[i] * s1_dse_y_ff;
            s2_ph_ff[i] <= s1_ed_y_ff[i] * s1_dse_x_ff;
            s2_ds_ff[i] <= NEAR_SQ_W'(s1_ns_x_ff[i]) * NEAR_SQ_W'(s1_ns_x_ff[i])
                           + NEAR_SQ_W'(s1_ns_y_ff[i]) * NEAR_SQ_W'(s1_ns_y_ff[i]);
            s2_de_ff[i] <= NEAR_SQ_W'(s1_ne_x_ff[i]) * NEAR_SQ_W'(s1_ne_x_ff[i])
                           + NEAR_SQ_W'(s1_ne_y_ff[i]) * NEAR_SQ_W'(s1_ne_y_ff[i]);
         end
         s2_pt_ff[0] <= s1_ed_y_ff[0] * s1_ed_x_ff[2];
         s2_pt_ff[1] <= s1_ed_x_ff[0] * s1_ed_y_ff[2];
         s2_pq_ff[0] <= s1_ed_y_ff[1] * s1_ase_x_ff[2];
         s2_pq_ff[1] <= s1_ed_x_ff[1] * s1_ase_y_ff[2];
         s2_pq_ff[2] <= s1_ed_y_ff[1] * s1_aee_x_ff[2];
         s2_pq_ff[3] <= s1_ed_x_ff[1] * s1_aee_y_ff[2];

         s3_elem_ff <= s2_elem_ff;
         s3_geo_ff  <= s2_geo_ff;
         for (int i = 0; i < 3; i++) begin
            s3_os_ff[i] <= cross_sub(s2_pa_ff[i], s2_pb_ff[i]);
            s3_t3_ff[i] <= cross_sub(s2_pc_ff[i], s2_pd_ff[i]);
            s3_t4_ff[i] <= cross_sub(s2_pe_ff[i], s2_pf_ff[i]);
            s3_dt_ff[i] <= cross_sub(s2_pg_ff[i], s2_ph_ff[i]);
         end
         s3_dtri_ff   <= cross_sub(s2_pt_ff[0], s2_pt_ff[1]);
         s3_l0s_ff    <= cross_sub(s2_pq_ff[0], s2_pq_ff[1]);
         s3_l0e_ff    <= cross_sub(s2_pq_ff[2], s2_pq_ff[3]);
         s3_near_s_ff <= (s2_ns_ok_ff[0] && s2_ds_ff[0] < NEAR_SQ_W'(tol_sq_ff))
                         || (s2_ns_ok_ff[1] && s2_ds_ff[1] < NEAR_SQ_W'(tol_sq_ff))
                         || (s2_ns_ok_ff[2] && s2_ds_ff[2] < NEAR_SQ_W'(tol_sq_ff));
         s3_near_e_ff <= (s2_ne_ok_ff[0] && s2_de_ff[0] < NEAR_SQ_W'(tol_sq_ff))
                         || (s2_ne_ok_ff[1] && s2_de_ff[1] < NEAR_SQ_W'(tol_sq_ff))
                         || (s2_ne_ok_ff[2] && s2_de_ff[2] < NEAR_SQ_W'(tol_sq_ff));

         for (int j = 0; j <= ALPHA_BITS; j++) begin
            dv_elem_ff[j] <= dv_elem_in[j];
            dv_cy_ff[j]   <= dv_cy_in[j];
            for (int k = 0; k < 3; k++) begin
               dv_r_ff[j][k] <= dv_r_in[j][k];
               dv_d_ff[j][k] <= dv_d_in[j][k];
               dv_q_ff[j][k] <= dv_q_in[j][k];
            end
         end

         dc_has_ff  <= dc_has_in;
         dc_kind_ff <= dc_kind_in;
         dc_c1_ff   <= dc_c1_in;
         dc_c2_ff   <= dc_c2_in;
         dc_usev_ff <= dc_usev_in;
         dc_vert_ff <= dc_vert_in;
         dc_elem_ff <= dv_elem_ff[ALPHA_BITS];
         dc_s_ff    <= cy.geo.s;
         dc_e_ff    <= cy.geo.e;

         lm_has_ff   <= dc_has_ff;
         lm_kind_ff  <= dc_kind_ff;
         lm_usev_ff  <= dc_usev_ff;
         lm_vert_ff  <= dc_vert_ff;
         lm_elem_ff  <= dc_elem_ff;
         lm_s_ff     <= dc_s_ff;
         lm_neg_x_ff <= lx_diff[DIFF_W-1];
         lm_neg_y_ff <= ly_diff[DIFF_W-1];
         lm_px1_ff   <= LERP_W'(lx_mag) * LERP_W'(dc_c1_ff);
         lm_py1_ff   <= LERP_W'(ly_mag) * LERP_W'(dc_c1_ff);
         lm_px2_ff   <= LERP_W'(lx_mag) * LERP_W'(dc_c2_ff);
         lm_py2_ff   <= LERP_W'(ly_mag) * LERP_W'(dc_c2_ff);

         rsp_id_ff   <= {1'b0, lm_elem_ff} + (EW + 1)'(1);
         rsp_p0_ff   <= rsp_p0_in;
         rsp_p1_ff   <= rsp_p1_in;
         rsp_case_ff <= lm_kind_ff;
      end
   end

endmodule
